// ===== sv/mmts_pkg.sv =====
// ----------------------------------------------------------------------------
// mmts_pkg
// Types, element tables and field layout for the march memory test sequencer.
// ----------------------------------------------------------------------------
package mmts_pkg;

  localparam int ADDR_W = 15;
  localparam int ERR_W  = 15;
  localparam int ELEM_W = 4;
  localparam int ELEMS  = 16;

  localparam logic [ERR_W-1:0]  ERR_MAX   = '1;
  localparam logic [ELEM_W-1:0] LAST_ELEM = 4'd15;
  localparam logic [15:0]       CAP_RESET = 16'h8000;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  // one bit per element, bit i for element i
  localparam logic [ELEMS-1:0] ELEM_DOWN   = 16'hAA8E;
  localparam logic [ELEMS-1:0] ELEM_READS  = 16'hFFFC;
  localparam logic [ELEMS-1:0] ELEM_WRITES = 16'h7FFF;

  typedef logic [7:0] bg_table_t [ELEMS];

  localparam bg_table_t ELEM_EXPECT = '{
    8'h00, 8'h00, 8'h00, 8'hff, 8'h00, 8'hff, 8'h00, 8'h55,
    8'haa, 8'h55, 8'h33, 8'hcc, 8'h33, 8'h0f, 8'hf0, 8'h0f
  };

  localparam bg_table_t ELEM_WDATA = '{
    8'h00, 8'h00, 8'hff, 8'h00, 8'hff, 8'h00, 8'h55, 8'haa,
    8'h55, 8'h33, 8'hcc, 8'h33, 8'h0f, 8'hf0, 8'h0f, 8'h00
  };

  // result payload, lowest field last
  typedef struct packed {
    logic [6:0]        pad;
    logic              test_done;
    logic [ERR_W-1:0]  error_count;
    logic [ADDR_W-1:0] next_address;
    logic              mismatch;
    logic              read_checked;
    logic [7:0]        write_data;
    logic              write_en;
    logic [ADDR_W-1:0] address;
  } result_t;

endpackage

// ===== sv/march_memory_test_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// march_memory_test_sequencer_core
// Byte-wide march test sequencer: one memory access per step transaction.
// ----------------------------------------------------------------------------
// a result passes two registers on its way out, the input register and then the
// result register, and is held there while the output is stalled
// throughput: one transaction per cycle while the output is not stalled
// reset: rst clears the sequencer to idle and capacity_bytes to 32768;
// no clearing pass, the block accepts input right after reset
module march_memory_test_sequencer_core #(
  parameter int MEM_BYTES   = 32768,
  parameter int BLOCK_BYTES = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,    // capacity_bytes
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,        // read_data
  input  logic        s_tuser,        // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,        // address, write_en, write_data, read_checked,
                                      // mismatch, next_address, error_count,
                                      // test_done, zero fill
  output logic        m_tlast         // block_done
);

  localparam int BASE_W = $clog2(MEM_BYTES);
  localparam int OFF_W  = $clog2(BLOCK_BYTES);
  localparam int BS_W   = OFF_W + 1;
  localparam int CAP_W  = 17;
  localparam int W      = 18;

  localparam logic [CAP_W-1:0] MEM_CAP = CAP_W'(MEM_BYTES);
  localparam logic [CAP_W-1:0] BLK_CAP = CAP_W'(BLOCK_BYTES);

  logic [15:0] capacity_bytes;

  logic                       running, running_next;
  logic [mmts_pkg::ELEM_W-1:0] element_index, element_index_next;
  logic [OFF_W-1:0]           offset_in_block, offset_in_block_next;
  logic [BASE_W-1:0]          block_base, block_base_next;
  logic [mmts_pkg::ERR_W-1:0]  block_errors, block_errors_next;

  logic       in_valid;
  logic       in_op;
  logic [7:0] in_read_data;

  logic                out_valid;
  mmts_pkg::result_t   out_result;
  logic                out_block_done;

  mmts_pkg::result_t   res;
  logic                res_block_done;

  logic               advance;
  logic               fire;
  logic [CAP_W-1:0]   eff_cap;
  logic [BS_W-1:0]    bs;
  logic               reads;
  logic               mism;

  function automatic logic [mmts_pkg::ADDR_W-1:0] addr_of(
    input logic [BASE_W-1:0] base,
    input logic              down,
    input logic [OFF_W-1:0]  off,
    input logic [BS_W-1:0]   size
  );
    logic [W-1:0] sum;
    if (down) begin
      sum = W'(base) + W'(size) - W'(1) - W'(off);
    end else begin
      sum = W'(base) + W'(off);
    end
    return sum[mmts_pkg::ADDR_W-1:0];
  endfunction

  assign advance  = !out_valid || m_tready;
  assign fire     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  assign m_tvalid = out_valid;
  assign m_tdata  = out_result;
  assign m_tlast  = out_block_done;

  // capacity clamp and block size
  always_comb begin
    if (capacity_bytes == '0) begin
      eff_cap = CAP_W'(1);
    end else if ({1'b0, capacity_bytes} > MEM_CAP) begin
      eff_cap = MEM_CAP;
    end else begin
      eff_cap = {1'b0, capacity_bytes};
    end
    if (eff_cap > BLK_CAP) begin
      bs = BS_W'(BLOCK_BYTES);
    end else begin
      bs = eff_cap[BS_W-1:0];
    end
  end

  always_comb begin
    running_next         = running;
    element_index_next   = element_index;
    offset_in_block_next = offset_in_block;
    block_base_next      = block_base;
    block_errors_next    = block_errors;
    res                  = '0;
    res_block_done       = 1'b0;
    reads                = mmts_pkg::ELEM_READS[element_index];
    mism                 = reads && (in_read_data != mmts_pkg::ELEM_EXPECT[element_index]);

    if (in_op == mmts_pkg::OP_START) begin
      running_next         = 1'b1;
      element_index_next   = '0;
      offset_in_block_next = '0;
      block_base_next      = '0;
      block_errors_next    = '0;
    end else if (running) begin
      if (mism && block_errors != mmts_pkg::ERR_MAX) begin
        block_errors_next = block_errors + 1'b1;
      end
      res.address      = addr_of(block_base, mmts_pkg::ELEM_DOWN[element_index],
                                 offset_in_block, bs);
      res.write_en     = mmts_pkg::ELEM_WRITES[element_index];
      res.write_data   = mmts_pkg::ELEM_WRITES[element_index] ?
                         mmts_pkg::ELEM_WDATA[element_index] : 8'h00;
      res.read_checked = reads;
      res.mismatch     = mism;
      res.error_count  = block_errors_next;

      if (BS_W'(offset_in_block) + BS_W'(1) < bs) begin
        offset_in_block_next = offset_in_block + 1'b1;
      end else begin
        offset_in_block_next = '0;
        if (element_index != mmts_pkg::LAST_ELEM) begin
          element_index_next = element_index + 1'b1;
        end else begin
          res_block_done     = 1'b1;
          element_index_next = '0;
          block_errors_next  = '0;
          if (W'(block_base) + W'(bs) >= W'(eff_cap)) begin
            res.test_done = 1'b1;
            running_next  = 1'b0;
          end else begin
            block_base_next = BASE_W'(W'(block_base) + W'(bs));
          end
        end
      end
      if (running_next) begin
        res.next_address = addr_of(block_base_next,
                                   mmts_pkg::ELEM_DOWN[element_index_next],
                                   offset_in_block_next, bs);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_bytes  <= mmts_pkg::CAP_RESET;
      running         <= 1'b0;
      element_index   <= '0;
      offset_in_block <= '0;
      block_base      <= '0;
      block_errors    <= '0;
      in_valid        <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        capacity_bytes <= cfg_wr_data;
      end
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        out_valid <= in_valid;
      end
      if (fire) begin
        running         <= running_next;
        element_index   <= element_index_next;
        offset_in_block <= offset_in_block_next;
        block_base      <= block_base_next;
        block_errors    <= block_errors_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op        <= s_tuser;
      in_read_data <= s_tdata;
    end
    if (fire) begin
      out_result     <= res;
      out_block_done <= res_block_done;
    end
  end

endmodule

// ===== sv/mmts_checker.sv =====
// ----------------------------------------------------------------------------
// mmts_checker
// Port-level checks for the march test sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module mmts_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic        m_tlast
);

  mmts_pkg::result_t r;
  assign r = m_tdata;

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // end of test is always the end of a block, and leaves no next address
  a_test_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && r.test_done |-> m_tlast && r.next_address == '0)
    else $error("test end without block end");

  // a mismatch is always counted
  a_mismatch_counted: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && r.mismatch |-> r.read_checked && r.error_count != '0)
    else $error("mismatch not counted");

  // with the input side idle, the output cannot start
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid && !(s_tvalid && s_tready) ##1 !m_tvalid |=> !m_tvalid)
    else $error("result without transaction");

endmodule

bind march_memory_test_sequencer_core mmts_checker u_mmts_checker (.*);

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// march memory test sequencer testbench
// Drives start and step transactions and answers every announced address from
// a shadow of the memory, with some bytes corrupted. An in-bench model of the
// sweep order predicts each result, and every result is checked field by field.
// ----------------------------------------------------------------------------
module testbench;

  // slowest run: ~1000 items with stalls and idling, plus drains and
  // capacity writes; taken several times over
  localparam int CYCLE_LIMIT  = 100000;
  localparam int RANDOM_ITEMS = 720;
  localparam int SETTLE       = 4;
  localparam int DIR_ROWS     = 31;
  localparam int LAST_SWEEP   = 15;
  localparam int ERR_SAT      = 32767;
  localparam int CAP_MAX      = 32768;
  localparam int SWEEP_MAX    = 2048;

  // bit i belongs to sweep i
  localparam logic [15:0]  SWEEP_DOWN   = 16'hAA8E;
  localparam logic [15:0]  SWEEP_READS  = 16'hFFFC;
  localparam logic [15:0]  SWEEP_WRITES = 16'h7FFF;
  // byte i belongs to sweep i
  localparam logic [127:0] READ_BG  = 128'h0ff00f33cc3355aa5500ff00ff000000;
  localparam logic [127:0] WRITE_BG = 128'h000ff00f33cc3355aa5500ff00ff0000;
  // bytes fed to the one-byte test, wrong in the fifth and the last sweep
  localparam logic [127:0] DIR_READS = 128'h8ff00f33cc3355aa5500ff01ff00aa55;

  typedef struct packed {
    logic [14:0] address;
    logic        write_en;
    logic [7:0]  write_data;
    logic        read_checked;
    logic        mismatch;
    logic [14:0] next_address;
    logic [14:0] error_count;
    logic        block_done;
    logic        test_done;
  } seq_result_t;

  typedef enum logic {
    ROW_ITEM = 1'b0,
    ROW_CFG  = 1'b1
  } row_kind_t;

  typedef struct packed {
    row_kind_t     kind;
    mmts_pkg::op_t op;
    logic [15:0]   val;
    logic          lit;
    seq_result_t   res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = 16'h0000;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic        m_tlast;

  march_memory_test_sequencer_core uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast)
  );

  always #5 clk = ~clk;

  // sequencer model state
  logic [15:0] cap_reg = 16'h8000;
  bit          seq_running = 1'b0;
  int          seq_elem = 0;
  int          seq_off = 0;
  int          seq_base = 0;
  int          seq_errs = 0;
  logic [7:0]  shadow_mem [CAP_MAX];

  seq_result_t       expected_q [$];
  dir_row_t          dir_tbl [DIR_ROWS];
  bit                idle_on = 1'b1;
  int                errors = 0;
  int                cycles = 0;
  int                stall_left = 0;
  int                sent_count = 0;
  int                results_seen = 0;
  int                mism_seen = 0;
  int                blocks_seen = 0;
  seq_result_t       want;
  mmts_pkg::result_t got;

  function automatic int eff_cap();
    int c;
    c = cap_reg;
    if (c == 0) c = 1;
    if (c > CAP_MAX) c = CAP_MAX;
    return c;
  endfunction

  function automatic int sweep_size();
    return (eff_cap() > SWEEP_MAX) ? SWEEP_MAX : eff_cap();
  endfunction

  function automatic logic [14:0] sweep_addr(int e, int off, int bs);
    int a;
    a = SWEEP_DOWN[e] ? seq_base + bs - 1 - off : seq_base + off;
    return a[14:0];
  endfunction

  function automatic seq_result_t march_step(mmts_pkg::op_t op, logic [7:0] rd);
    seq_result_t r;
    int bs;
    int e;
    r = '0;
    if (op == mmts_pkg::OP_START) begin
      seq_running = 1'b1;
      seq_elem = 0;
      seq_off = 0;
      seq_base = 0;
      seq_errs = 0;
      r.address = sweep_addr(0, 0, sweep_size());
      r.next_address = r.address;
      return r;
    end
    if (!seq_running) return r;
    bs = sweep_size();
    e = seq_elem;
    r.address = sweep_addr(e, seq_off, bs);
    r.read_checked = SWEEP_READS[e];
    r.mismatch = SWEEP_READS[e] && (rd != READ_BG[e*8 +: 8]);
    if (r.mismatch && seq_errs < ERR_SAT) seq_errs++;
    r.error_count = seq_errs[14:0];
    r.write_en = SWEEP_WRITES[e];
    r.write_data = SWEEP_WRITES[e] ? WRITE_BG[e*8 +: 8] : 8'h00;
    if (seq_off + 1 < bs) begin
      seq_off++;
    end else begin
      seq_off = 0;
      if (e < LAST_SWEEP) begin
        seq_elem = e + 1;
      end else begin
        r.block_done = 1'b1;
        seq_elem = 0;
        seq_errs = 0;
        if (seq_base + bs >= eff_cap()) begin
          r.test_done = 1'b1;
          seq_running = 1'b0;
        end else begin
          seq_base += bs;
        end
      end
    end
    if (seq_running) r.next_address = sweep_addr(seq_elem, seq_off, bs);
    return r;
  endfunction

  // byte the memory holds at the announced address, now and then corrupted
  function automatic logic [7:0] pick_read();
    logic [7:0] d;
    if (!seq_running) return 8'($urandom);
    d = shadow_mem[sweep_addr(seq_elem, seq_off, sweep_size())];
    case ($urandom_range(0, 29))
      0: begin
        d = 8'($urandom);
      end
      1, 2: begin
        d = d ^ (8'h01 << $urandom_range(0, 7));
      end
      default: begin
      end
    endcase
    return d;
  endfunction

  task automatic send_item(mmts_pkg::op_t op, logic [7:0] rd, logic lit,
                           seq_result_t lit_res);
    seq_result_t r;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= rd;
    do @(posedge clk); while (!s_tready);
    r = march_step(op, rd);
    if (r.write_en) shadow_mem[r.address] = r.write_data;
    sent_count++;
    expected_q.push_back(lit ? lit_res : r);
  endtask

  task automatic drain_all();
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cap(logic [15:0] v);
    drain_all();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cap_reg = v;
    @(posedge clk);
  endtask

  task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      errors++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want_v, got_v);
    end
  endtask

  // result side: compare each transaction, then decide the next stall
  always @(posedge clk) begin
    if (m_tvalid && m_tready) begin
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, expected none actual %h", $time, m_tdata);
      end else begin
        want = expected_q.pop_front();
        got = mmts_pkg::result_t'(m_tdata);
        results_seen++;
        if (want.mismatch) mism_seen++;
        if (want.block_done) blocks_seen++;
        check_field("address", 32'(want.address), 32'(got.address));
        check_field("write_en", 32'(want.write_en), 32'(got.write_en));
        check_field("write_data", 32'(want.write_data), 32'(got.write_data));
        check_field("read_checked", 32'(want.read_checked), 32'(got.read_checked));
        check_field("mismatch", 32'(want.mismatch), 32'(got.mismatch));
        check_field("next_address", 32'(want.next_address), 32'(got.next_address));
        check_field("error_count", 32'(want.error_count), 32'(got.error_count));
        check_field("test_done", 32'(want.test_done), 32'(got.test_done));
        check_field("block_done", 32'(want.block_done), 32'(m_tlast));
        check_field("zero fill", 32'(0), 32'(got.pad));
      end
    end
    if (!idle_on) begin
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 6) == 0) begin
      stall_left = $urandom_range(0, 3);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time, expected_q.size());
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    int          target;
    int          bs;
    int          n_steps;
    logic [15:0] cap_v;

    for (int i = 0; i < CAP_MAX; i++) shadow_mem[i] = 8'($urandom);

    // after reset, first steps of a full-size test, restarts
    dir_tbl[0]  = '{ROW_ITEM, mmts_pkg::OP_STEP, 16'h00ff, 1'b1, '0};
    dir_tbl[1]  = '{ROW_ITEM, mmts_pkg::OP_STEP, 16'h0000, 1'b1, '0};
    dir_tbl[2]  = '{ROW_ITEM, mmts_pkg::OP_START, 16'h0000, 1'b1, '0};
    dir_tbl[3]  = '{ROW_ITEM, mmts_pkg::OP_STEP, 16'h00ff, 1'b1,
                    '{15'd0, 1'b1, 8'h00, 1'b0, 1'b0, 15'd1, 15'd0, 1'b0, 1'b0}};
    dir_tbl[4]  = '{ROW_ITEM, mmts_pkg::OP_STEP, 16'h00a5, 1'b1,
                    '{15'd1, 1'b1, 8'h00, 1'b0, 1'b0, 15'd2, 15'd0, 1'b0, 1'b0}};
    dir_tbl[5]  = '{ROW_ITEM, mmts_pkg::OP_START, 16'h0000, 1'b1, '0};
    // one-byte memory: every sweep once, two bad reads
    dir_tbl[6]  = '{ROW_CFG, mmts_pkg::OP_STEP, 16'h0001, 1'b0, '0};
    dir_tbl[7]  = '{ROW_ITEM, mmts_pkg::OP_START, 16'h0000, 1'b0, '0};
    for (int k = 0; k < 16; k++)
      dir_tbl[8+k] = '{ROW_ITEM, mmts_pkg::OP_STEP, {8'h00, DIR_READS[k*8 +: 8]}, 1'b0, '0};
    dir_tbl[23] = '{ROW_ITEM, mmts_pkg::OP_STEP, 16'h008f, 1'b1,
                    '{15'd0, 1'b0, 8'h00, 1'b1, 1'b1, 15'd0, 15'd2, 1'b1, 1'b1}};
    // step once the test has ended
    dir_tbl[24] = '{ROW_ITEM, mmts_pkg::OP_STEP, 16'h003c, 1'b1, '0};
    // zero capacity, then capacity raised to the maximum mid-test
    dir_tbl[25] = '{ROW_CFG, mmts_pkg::OP_STEP, 16'h0000, 1'b0, '0};
    dir_tbl[26] = '{ROW_ITEM, mmts_pkg::OP_START, 16'h0000, 1'b0, '0};
    dir_tbl[27] = '{ROW_ITEM, mmts_pkg::OP_STEP, 16'h0000, 1'b0, '0};
    dir_tbl[28] = '{ROW_CFG, mmts_pkg::OP_STEP, 16'hffff, 1'b0, '0};
    dir_tbl[29] = '{ROW_ITEM, mmts_pkg::OP_STEP, 16'h0000, 1'b0, '0};
    dir_tbl[30] = '{ROW_ITEM, mmts_pkg::OP_STEP, 16'h0011, 1'b0, '0};

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].kind == ROW_CFG) begin
        write_cap(dir_tbl[i].val);
      end else begin
        send_item(dir_tbl[i].op, dir_tbl[i].val[7:0], dir_tbl[i].lit, dir_tbl[i].res);
      end
    end

    // random phases; a phase without a start carries on after a capacity change
    target = sent_count + RANDOM_ITEMS;
    while (sent_count < target) begin
      case ($urandom_range(0, 15))
        0: cap_v = 16'h0000;
        1: cap_v = 16'h0001;
        2: cap_v = 16'($urandom_range(2049, 65535));
        3: cap_v = $urandom_range(0, 1) ? 16'd2048 : 16'd2047;
        4: cap_v = 16'($urandom_range(8, 40));
        default: cap_v = 16'($urandom_range(1, 6));
      endcase
      write_cap(cap_v);
      idle_on = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 4) != 0) send_item(mmts_pkg::OP_START, 8'($urandom), 1'b0, '0);
      bs = sweep_size();
      n_steps = (bs <= 8) ? 16 * bs + $urandom_range(0, 3) : $urandom_range(20, 120);
      repeat (n_steps) begin
        case ($urandom_range(0, 59))
          0: send_item(mmts_pkg::OP_START, 8'($urandom), 1'b0, '0);
          1: drain_all();
          default: send_item(mmts_pkg::OP_STEP, pick_read(), 1'b0, '0);
        endcase
      end
    end

    // one whole small test back to back, no idling
    idle_on = 1'b0;
    write_cap(16'($urandom_range(2, 6)));
    send_item(mmts_pkg::OP_START, 8'($urandom), 1'b0, '0);
    while (seq_running) send_item(mmts_pkg::OP_STEP, pick_read(), 1'b0, '0);
    send_item(mmts_pkg::OP_STEP, 8'($urandom), 1'b0, '0);

    drain_all();
    $display("sent %0d transactions, checked %0d results", sent_count, results_seen);
    $display("%0d bad reads flagged, %0d blocks completed", mism_seen, blocks_seen);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
